@@ sv/decimal_long_multiplier_defines.svh @@
// ----------------------------------------------------------------------------
// Decimal long multiplier assertion macros
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_LONG_MULTIPLIER_DEFINES_SVH
`define DECIMAL_LONG_MULTIPLIER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define DLM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decimal_long_multiplier: assertion failed");

`define DLM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decimal_long_multiplier: assertion failed");

`else

`define DLM_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define DLM_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/dlm_pkg.sv @@
// ----------------------------------------------------------------------------
// Decimal long multiplier package
// Beat types, microcode control word, control store and digit helpers.
// ----------------------------------------------------------------------------
package dlm_pkg;

    localparam int MAX_DIGITS_DEF = 64;

    localparam logic [3:0] DIGIT_MAX = 4'd9;

    localparam logic [1:0] MODE_LOAD_A = 2'd0;
    localparam logic [1:0] MODE_LOAD_B = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] digit_in;
    } t_in_item;

    typedef struct packed {
        logic [3:0] product_digit;
        logic       last_digit;
        logic       too_long;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_IDLE,
        OP_INIT,
        OP_CLR,
        OP_ROW,
        OP_MUL_RD,
        OP_MUL_ACC,
        OP_ADD_RD,
        OP_ADD_ACC,
        OP_NEXT_ROW,
        OP_TOP,
        OP_SCAN_RD,
        OP_SCAN,
        OP_OUT_RD,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_READ,
        C_READY,
        C_CLR_MORE,
        C_ROW_END,
        C_I_END,
        C_NO_CARRY,
        C_SCAN_MORE,
        C_OUT_BUSY
    } t_cond;

    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] t_upc;

    localparam t_upc PC_IDLE     = 4'd0;
    localparam t_upc PC_DISPATCH = 4'd1;
    localparam t_upc PC_CLR      = 4'd2;
    localparam t_upc PC_ROW      = 4'd3;
    localparam t_upc PC_MUL_RD   = 4'd4;
    localparam t_upc PC_MUL_ACC  = 4'd5;
    localparam t_upc PC_ADD_RD   = 4'd6;
    localparam t_upc PC_ADD_ACC  = 4'd7;
    localparam t_upc PC_NEXT_ROW = 4'd8;
    localparam t_upc PC_TOP      = 4'd9;
    localparam t_upc PC_SCAN_RD  = 4'd10;
    localparam t_upc PC_SCAN     = 4'd11;
    localparam t_upc PC_OUT_RD   = 4'd12;
    localparam t_upc PC_EMIT     = 4'd13;
    localparam t_upc PC_RET      = 4'd14;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_ctl_word;

    typedef struct packed {
        logic read_cmd;
        logic ready;
        logic clr_more;
        logic row_end;
        logic i_end;
        logic no_carry;
        logic scan_more;
        logic out_busy;
    } t_dp_status;

    typedef struct packed {
        logic [3:0] q;
        logic [3:0] r;
    } t_div10;

    // jump to target when cond holds, else step to the next word
    function automatic t_ctl_word ucode(input t_upc pc);
        t_ctl_word w;
        case (pc)
            PC_IDLE:     w = '{OP_IDLE,     C_NO_READ,   PC_IDLE};
            PC_DISPATCH: w = '{OP_INIT,     C_READY,     PC_OUT_RD};
            PC_CLR:      w = '{OP_CLR,      C_CLR_MORE,  PC_CLR};
            PC_ROW:      w = '{OP_ROW,      C_ROW_END,   PC_TOP};
            PC_MUL_RD:   w = '{OP_MUL_RD,   C_I_END,     PC_ADD_RD};
            PC_MUL_ACC:  w = '{OP_MUL_ACC,  C_ALWAYS,    PC_MUL_RD};
            PC_ADD_RD:   w = '{OP_ADD_RD,   C_NO_CARRY,  PC_NEXT_ROW};
            PC_ADD_ACC:  w = '{OP_ADD_ACC,  C_ALWAYS,    PC_ADD_RD};
            PC_NEXT_ROW: w = '{OP_NEXT_ROW, C_ALWAYS,    PC_ROW};
            PC_TOP:      w = '{OP_TOP,      C_NEVER,     PC_IDLE};
            PC_SCAN_RD:  w = '{OP_SCAN_RD,  C_NEVER,     PC_IDLE};
            PC_SCAN:     w = '{OP_SCAN,     C_SCAN_MORE, PC_SCAN_RD};
            PC_OUT_RD:   w = '{OP_OUT_RD,   C_NEVER,     PC_IDLE};
            PC_EMIT:     w = '{OP_EMIT,     C_OUT_BUSY,  PC_EMIT};
            PC_RET:      w = '{OP_NOP,      C_ALWAYS,    PC_IDLE};
            default:     w = '{OP_NOP,      C_ALWAYS,    PC_IDLE};
        endcase
        return w;
    endfunction

    // valid for t up to 99
    function automatic t_div10 div10(input logic [6:0] t);
        logic [14:0] m;
        logic [3:0]  q;
        logic [6:0]  r;
        m = 15'(t) * 15'd205;
        q = m[14:11];
        r = t - 7'(q) * 7'd10;
        return '{q: q, r: r[3:0]};
    endfunction

endpackage

@@ sv/dlm_stream_if.sv @@
// ----------------------------------------------------------------------------
// Decimal long multiplier stream interface
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface dlm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/dlm_ram.sv @@
// ----------------------------------------------------------------------------
// Decimal long multiplier RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dlm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/dlm_sequencer.sv @@
// ----------------------------------------------------------------------------
// Decimal long multiplier sequencer
// Micro program counter stepping through the control store.
// ----------------------------------------------------------------------------
module dlm_sequencer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dlm_pkg::t_dp_status   i_status,
    output dlm_pkg::t_ctl_word    o_ctl
);

    dlm_pkg::t_upc      r_pc;
    dlm_pkg::t_upc      n_pc;
    dlm_pkg::t_ctl_word ctl;
    logic               take;

    assign ctl = dlm_pkg::ucode(r_pc);

    always_comb begin
        case (ctl.cond)
            dlm_pkg::C_NEVER:     take = 1'b0;
            dlm_pkg::C_ALWAYS:    take = 1'b1;
            dlm_pkg::C_NO_READ:   take = !i_status.read_cmd;
            dlm_pkg::C_READY:     take = i_status.ready;
            dlm_pkg::C_CLR_MORE:  take = i_status.clr_more;
            dlm_pkg::C_ROW_END:   take = i_status.row_end;
            dlm_pkg::C_I_END:     take = i_status.i_end;
            dlm_pkg::C_NO_CARRY:  take = i_status.no_carry;
            dlm_pkg::C_SCAN_MORE: take = i_status.scan_more;
            dlm_pkg::C_OUT_BUSY:  take = i_status.out_busy;
            default:              take = 1'b1;
        endcase
        n_pc = take ? ctl.target : r_pc + dlm_pkg::t_upc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= dlm_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl = ctl;

endmodule

@@ sv/dlm_datapath.sv @@
// ----------------------------------------------------------------------------
// Decimal long multiplier datapath
// Operand and product stores, digit counters, multiply-add-carry unit.
// ----------------------------------------------------------------------------
`include "decimal_long_multiplier_defines.svh"

module dlm_datapath #(
    parameter int MAX_DIGITS = dlm_pkg::MAX_DIGITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dlm_stream_if.sink            i_in,
    dlm_stream_if.source          o_out,
    input  dlm_pkg::t_ctl_word    i_ctl,
    output dlm_pkg::t_dp_status   o_status
);

    localparam int PROD = 2 * MAX_DIGITS;
    localparam int AW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int PW   = $clog2(PROD);
    localparam int CW   = $clog2(MAX_DIGITS + 1);
    localparam int KW   = $clog2(PROD + 1);

    logic [CW-1:0] r_first_cnt;
    logic [CW-1:0] r_second_cnt;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [KW-1:0] r_k;
    logic [3:0]    r_carry;
    logic [PW-1:0] r_rpos;
    logic          r_ready;
    logic          r_ovf;
    logic          r_out_valid;
    dlm_pkg::t_out_item r_out;

    logic          in_fire;
    logic [1:0]    mode;
    logic [3:0]    dsat;
    logic          load_ok;
    logic          first_full;
    logic          second_full;
    logic          out_busy;
    logic          emit;
    logic          scan_more;

    logic          a_we, a_re, b_we, b_re, p_we, p_re;
    logic [AW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
    logic [PW-1:0] p_waddr, p_raddr;
    logic [3:0]    a_rdata, b_rdata, p_rdata, p_wdata;
    logic [CW-1:0] a_idx, b_idx;
    logic [6:0]    mul;
    logic [6:0]    t_sum;
    dlm_pkg::t_div10 dv;
    logic [CW:0]   top_sum;

    assign i_in.ready = (i_ctl.op == dlm_pkg::OP_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign mode       = i_in.data.mode;
    assign dsat       = (i_in.data.digit_in > dlm_pkg::DIGIT_MAX) ? dlm_pkg::DIGIT_MAX
                                                                  : i_in.data.digit_in;
    assign load_ok     = in_fire && !r_ready;
    assign first_full  = (r_first_cnt == CW'(MAX_DIGITS));
    assign second_full = (r_second_cnt == CW'(MAX_DIGITS));

    assign a_we    = load_ok && (mode == dlm_pkg::MODE_LOAD_A) && !first_full;
    assign b_we    = load_ok && (mode == dlm_pkg::MODE_LOAD_B) && !second_full;
    assign a_waddr = r_first_cnt[AW-1:0];
    assign b_waddr = r_second_cnt[AW-1:0];

    assign a_idx   = r_first_cnt - r_i - CW'(1);
    assign b_idx   = r_second_cnt - r_j - CW'(1);
    assign a_raddr = a_idx[AW-1:0];
    assign b_raddr = b_idx[AW-1:0];
    assign a_re    = (i_ctl.op == dlm_pkg::OP_MUL_RD);
    assign b_re    = (i_ctl.op == dlm_pkg::OP_ROW);

    assign p_re    = (i_ctl.op == dlm_pkg::OP_MUL_RD) || (i_ctl.op == dlm_pkg::OP_ADD_RD)
                  || (i_ctl.op == dlm_pkg::OP_SCAN_RD) || (i_ctl.op == dlm_pkg::OP_OUT_RD);
    assign p_raddr = (i_ctl.op == dlm_pkg::OP_OUT_RD) ? r_rpos : r_k[PW-1:0];

    assign mul   = (i_ctl.op == dlm_pkg::OP_MUL_ACC) ? 7'(a_rdata) * 7'(b_rdata) : 7'd0;
    assign t_sum = 7'(p_rdata) + mul + 7'(r_carry);
    assign dv    = dlm_pkg::div10(t_sum);

    assign p_we    = (i_ctl.op == dlm_pkg::OP_CLR) || (i_ctl.op == dlm_pkg::OP_MUL_ACC)
                  || (i_ctl.op == dlm_pkg::OP_ADD_ACC);
    assign p_waddr = r_k[PW-1:0];
    assign p_wdata = (i_ctl.op == dlm_pkg::OP_CLR) ? 4'd0 : dv.r;

    assign top_sum   = (CW+1)'(r_first_cnt) + (CW+1)'(r_second_cnt);
    assign out_busy  = r_out_valid && !o_out.ready;
    assign emit      = (i_ctl.op == dlm_pkg::OP_EMIT) && !out_busy;
    assign scan_more = (r_k != '0) && (p_rdata == 4'd0);

    dlm_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_first (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (dsat),
        .i_re    (a_re),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    dlm_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_second (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (dsat),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    dlm_ram #(.WIDTH(4), .DEPTH(PROD)) u_product (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_re    (p_re),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_cnt  <= '0;
            r_second_cnt <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_k          <= '0;
            r_carry      <= '0;
            r_rpos       <= '0;
            r_ready      <= 1'b0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_ctl.op)
                dlm_pkg::OP_IDLE: begin
                    if (a_we) begin
                        r_first_cnt <= r_first_cnt + CW'(1);
                    end
                    if (b_we) begin
                        r_second_cnt <= r_second_cnt + CW'(1);
                    end
                    if (load_ok && ((mode == dlm_pkg::MODE_LOAD_A && first_full)
                                 || (mode == dlm_pkg::MODE_LOAD_B && second_full))) begin
                        r_ovf <= 1'b1;
                    end
                end
                dlm_pkg::OP_INIT: begin
                    r_k <= '0;
                    r_j <= '0;
                end
                dlm_pkg::OP_CLR: begin
                    r_k <= r_k + KW'(1);
                end
                dlm_pkg::OP_ROW: begin
                    r_k     <= KW'(r_j);
                    r_i     <= '0;
                    r_carry <= '0;
                end
                dlm_pkg::OP_MUL_ACC: begin
                    r_carry <= dv.q;
                    r_i     <= r_i + CW'(1);
                    r_k     <= r_k + KW'(1);
                end
                dlm_pkg::OP_ADD_ACC: begin
                    r_carry <= dv.q;
                    r_k     <= r_k + KW'(1);
                end
                dlm_pkg::OP_NEXT_ROW: begin
                    r_j <= r_j + CW'(1);
                end
                dlm_pkg::OP_TOP: begin
                    r_k <= (top_sum == '0) ? '0 : KW'(top_sum - (CW+1)'(1));
                end
                dlm_pkg::OP_SCAN: begin
                    if (scan_more) begin
                        r_k <= r_k - KW'(1);
                    end else begin
                        r_rpos  <= r_k[PW-1:0];
                        r_ready <= 1'b1;
                    end
                end
                dlm_pkg::OP_EMIT: begin
                    if (emit) begin
                        r_out_valid <= 1'b1;
                        if (r_rpos == '0) begin
                            r_first_cnt  <= '0;
                            r_second_cnt <= '0;
                            r_ready      <= 1'b0;
                            r_ovf        <= 1'b0;
                        end else begin
                            r_rpos <= r_rpos - PW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.product_digit <= p_rdata;
            r_out.last_digit    <= (r_rpos == '0);
            r_out.too_long      <= r_ovf;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        o_status.read_cmd  = in_fire && (mode == dlm_pkg::MODE_READ);
        o_status.ready     = r_ready;
        o_status.clr_more  = (r_k != KW'(PROD - 1));
        o_status.row_end   = (r_j == r_second_cnt);
        o_status.i_end     = (r_i == r_first_cnt);
        o_status.no_carry  = (r_carry == 4'd0) || (r_k >= KW'(PROD));
        o_status.scan_more = scan_more;
        o_status.out_busy  = out_busy;
    end

    `DLM_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, (r_first_cnt <= CW'(MAX_DIGITS)) && (r_second_cnt <= CW'(MAX_DIGITS)))
    `DLM_ASSERT_IMP(a_carry_digit, i_clk, i_rst_n, 1'b1, r_carry <= dlm_pkg::DIGIT_MAX)
    `DLM_ASSERT_NXT(a_last_clears, i_clk, i_rst_n, emit && (r_rpos == '0), !r_ready && (r_first_cnt == '0) && !r_ovf)
    `DLM_ASSERT_NXT(a_load_ignored, i_clk, i_rst_n, in_fire && r_ready && (mode != dlm_pkg::MODE_READ), $stable(r_first_cnt) && $stable(r_second_cnt) && $stable(r_ovf))

endmodule

@@ sv/decimal_long_multiplier.sv @@
// ----------------------------------------------------------------------------
// Decimal long multiplier
// Operand digit beats are taken back to back while idle. A read beat steps
// through dispatch, product read and emit before the next beat is taken; its
// digit is registered on the output, and output stalls hold the emit step.
// The first read of a job sweeps the 2*MAX_DIGITS product store to zero, then
// multiplies row by row. Reset clears counters and flags only.
// ----------------------------------------------------------------------------
module decimal_long_multiplier #(
    parameter int MAX_DIGITS = dlm_pkg::MAX_DIGITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dlm_stream_if.sink    i_in,
    dlm_stream_if.source  o_out
);

    dlm_pkg::t_ctl_word  ctl;
    dlm_pkg::t_dp_status status;

    dlm_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctl    (ctl)
    );

    dlm_datapath #(.MAX_DIGITS(MAX_DIGITS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_ctl    (ctl),
        .o_status (status)
    );

endmodule
